// ----- rtl/pcpc_pkg.sv -----
`default_nettype none

package pcpc_pkg;

   // Cache geometry
   localparam int NUM_CLASSES = 8;
   localparam int STACK_DEPTH = 8;
   localparam int MAX_RESULTS = 64;

   // Field widths
   localparam int OP_W    = 2;
   localparam int CLASS_W = 3;
   localparam int PTR_W   = 48;
   localparam int KIND_W  = 2;

   // Derived widths
   localparam int CLS_IDX_W = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
   localparam int CLS_CNT_W = $clog2(NUM_CLASSES + 1);
   localparam int SLOT_W    = $clog2(STACK_DEPTH);
   localparam int COUNT_W   = $clog2(STACK_DEPTH + 1);
   localparam int NRES_W    = $clog2(MAX_RESULTS + 1);
   localparam int SUM_W     = ((NRES_W > COUNT_W) ? NRES_W : COUNT_W) + 2;
   localparam int MEM_AW    = CLS_IDX_W + SLOT_W;
   localparam int MEM_DEPTH = 2 ** MEM_AW;

   // Command queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Operation codes
   localparam logic [OP_W-1:0] OP_PUSH  = 2'd0;
   localparam logic [OP_W-1:0] OP_POP   = 2'd1;
   localparam logic [OP_W-1:0] OP_PURGE = 2'd2;

   // Result kinds
   localparam logic [KIND_W-1:0] KIND_HIT  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_MISS = 2'd1;
   localparam logic [KIND_W-1:0] KIND_GIVE = 2'd2;

   typedef struct packed {
      logic [OP_W-1:0]    operation;
      logic [CLASS_W-1:0] size_class;
      logic [PTR_W-1:0]   chunk_pointer;
   } req_type;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [CLASS_W-1:0] class_out;
      logic [PTR_W-1:0]   pointer_out;
      logic               last;
   } rsp_type;

   typedef enum logic [1:0] {
      CMD_PUSH,
      CMD_POP,
      CMD_PURGE
   } cmd_code_type;

   typedef struct packed {
      cmd_code_type         code;
      logic                 bad_class;
      logic [CLS_IDX_W-1:0] cls_idx;
      logic [CLASS_W-1:0]   size_class;
      logic [PTR_W-1:0]     chunk_pointer;
   } cmd_type;

   // Class field to internal class index
   function automatic logic [CLS_IDX_W-1:0] cls_to_idx(input logic [CLASS_W-1:0] c);
      logic [CLS_IDX_W+CLASS_W-1:0] wide;
      wide = {{CLS_IDX_W{1'b0}}, c};
      return wide[CLS_IDX_W-1:0];
   endfunction

   // Internal class index back to the class field
   function automatic logic [CLASS_W-1:0] idx_to_field(input logic [CLS_IDX_W-1:0] idx);
      logic [CLS_IDX_W+CLASS_W-1:0] wide;
      wide = {{CLASS_W{1'b0}}, idx};
      return wide[CLASS_W-1:0];
   endfunction

endpackage

`default_nettype wire

// ----- rtl/pcpc_front.sv -----
`default_nettype none

module pcpc_front (
   input  wire logic              req_valid,
   input  wire pcpc_pkg::req_type req_data,
   output logic                   req_stall,
   input  wire logic              q_full,
   output logic                   q_wr,
   output pcpc_pkg::cmd_type      q_data
);

   logic known_op;

   // Operation three is taken and dropped
   assign known_op = (req_data.operation == pcpc_pkg::OP_PUSH) ||
                     (req_data.operation == pcpc_pkg::OP_POP) ||
                     (req_data.operation == pcpc_pkg::OP_PURGE);

   assign req_stall = q_full;
   assign q_wr      = req_valid && !q_full && known_op;

   always_comb begin
      q_data.bad_class     = 32'(req_data.size_class) >= 32'(pcpc_pkg::NUM_CLASSES);
      q_data.cls_idx       = pcpc_pkg::cls_to_idx(req_data.size_class);
      q_data.size_class    = req_data.size_class;
      q_data.chunk_pointer = req_data.chunk_pointer;
      case (req_data.operation)
         pcpc_pkg::OP_PUSH: begin
            q_data.code = pcpc_pkg::CMD_PUSH;
         end
         pcpc_pkg::OP_POP: begin
            q_data.code = pcpc_pkg::CMD_POP;
         end
         default: begin
            q_data.code = pcpc_pkg::CMD_PURGE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ----- rtl/pcpc_queue.sv -----
`default_nettype none

module pcpc_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              wr_en,
   input  wire pcpc_pkg::cmd_type wr_data,
   output logic                   full,
   input  wire logic              rd_en,
   output pcpc_pkg::cmd_type      rd_data,
   output logic                   not_empty
);

   pcpc_pkg::cmd_type                 slots_ff [pcpc_pkg::QUEUE_DEPTH];
   logic [pcpc_pkg::QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [pcpc_pkg::QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [pcpc_pkg::QCNT_W-1:0]       fill_ff, fill_in;
   logic                              do_wr, do_rd;

   assign full      = fill_ff == pcpc_pkg::QCNT_W'(pcpc_pkg::QUEUE_DEPTH);
   assign not_empty = fill_ff != '0;
   assign rd_data   = slots_ff[rd_ptr_ff];
   assign do_wr     = wr_en && !full;
   assign do_rd     = rd_en && not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == pcpc_pkg::QPTR_W'(pcpc_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + pcpc_pkg::QPTR_W'(1);
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == pcpc_pkg::QPTR_W'(pcpc_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + pcpc_pkg::QPTR_W'(1);
      end
      if (do_wr && !do_rd) begin
         fill_in = fill_ff + pcpc_pkg::QCNT_W'(1);
      end else if (do_rd && !do_wr) begin
         fill_in = fill_ff - pcpc_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
      if (do_wr) begin
         slots_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/pcpc_back.sv -----
`default_nettype none

module pcpc_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              q_valid,
   input  wire pcpc_pkg::cmd_type q_data,
   output logic                   q_pop,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output pcpc_pkg::rsp_type      rsp_data
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_POP_RD,
      S_SCAN,
      S_GIVE
   } state_type;

   localparam int CW = pcpc_pkg::COUNT_W;
   localparam int SW = pcpc_pkg::SUM_W;

   state_type                        state_ff, state_in;
   logic [CW-1:0]                    count_ff [pcpc_pkg::NUM_CLASSES];
   logic [CW-1:0]                    count_in [pcpc_pkg::NUM_CLASSES];
   logic [CW-1:0]                    rate_ff  [pcpc_pkg::NUM_CLASSES];
   logic [CW-1:0]                    rate_in  [pcpc_pkg::NUM_CLASSES];
   logic [pcpc_pkg::CLS_IDX_W-1:0]   cls_ff, cls_in;
   logic [pcpc_pkg::CLS_CNT_W-1:0]   cur_ff, cur_in;
   logic [CW-1:0]                    take_ff, take_in;
   logic [CW-1:0]                    i_ff, i_in;
   logic [pcpc_pkg::NRES_W-1:0]      n_ff, n_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   pcpc_pkg::rsp_type                rsp_ff, rsp_in;

   logic [pcpc_pkg::PTR_W-1:0]       stack_mem_ff [pcpc_pkg::MEM_DEPTH];
   logic [pcpc_pkg::PTR_W-1:0]       rd_data_ff;
   logic                             rd_en, wr_en;
   logic [pcpc_pkg::MEM_AW-1:0]      rd_addr, wr_addr;

   logic                             out_free;
   logic                             emit;
   pcpc_pkg::rsp_type                emit_data;
   logic [CW-1:0]                    take_all [pcpc_pkg::NUM_CLASSES];

   // Search for the first non-empty class at or above cur_ff
   logic                             s_found;
   logic [pcpc_pkg::CLS_IDX_W-1:0]   s_idx;
   logic [CW-1:0]                    s_take, s_cnt, s_top;
   // Search for the next non-empty class above cls_ff
   logic [pcpc_pkg::CLS_CNT_W-1:0]   n_start;
   logic                             n_found;
   logic [CW-1:0]                    n_take;

   logic [CW-1:0]                    cnt_c, rate_c, cnt_m1, slot_off;
   logic [CW:0]                      rate_dbl;
   logic [CW-1:0]                    rate_next;
   logic                             last_slot, more;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      for (int k = 0; k < pcpc_pkg::NUM_CLASSES; k++) begin
         take_all[k] = (rate_ff[k] < count_ff[k]) ? rate_ff[k] : count_ff[k];
      end
   end

   // Lowest-index match wins
   always_comb begin
      n_start = pcpc_pkg::CLS_CNT_W'(cls_ff) + pcpc_pkg::CLS_CNT_W'(1);
      s_found = 1'b0;
      s_idx   = '0;
      s_take  = '0;
      s_cnt   = '0;
      n_found = 1'b0;
      n_take  = '0;
      for (int k = pcpc_pkg::NUM_CLASSES - 1; k >= 0; k--) begin
         if (count_ff[k] != '0 && pcpc_pkg::CLS_CNT_W'(k) >= cur_ff) begin
            s_found = 1'b1;
            s_idx   = pcpc_pkg::CLS_IDX_W'(k);
            s_take  = take_all[k];
            s_cnt   = count_ff[k];
         end
         if (count_ff[k] != '0 && pcpc_pkg::CLS_CNT_W'(k) >= n_start) begin
            n_found = 1'b1;
            n_take  = take_all[k];
         end
      end
   end

   always_comb begin
      cnt_c     = count_ff[cls_ff];
      rate_c    = rate_ff[cls_ff];
      rate_dbl  = {rate_c, 1'b0};
      rate_next = (rate_dbl > (CW + 1)'(pcpc_pkg::STACK_DEPTH)) ?
                  CW'(pcpc_pkg::STACK_DEPTH) : rate_dbl[CW-1:0];
      last_slot = i_ff == (take_ff - CW'(1));
      more      = n_found &&
                  (SW'(n_ff) + SW'(take_ff) + SW'(n_take) <= SW'(pcpc_pkg::MAX_RESULTS));
      slot_off  = cnt_c - i_ff - CW'(2);
      s_top     = s_cnt - CW'(1);
      cnt_m1    = count_ff[q_data.cls_idx] - CW'(1);
   end

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      rate_in  = rate_ff;
      cls_in   = cls_ff;
      cur_in   = cur_ff;
      take_in  = take_ff;
      i_in     = i_ff;
      n_in     = n_ff;
      q_pop    = 1'b0;
      rd_en    = 1'b0;
      rd_addr  = '0;
      wr_en    = 1'b0;
      wr_addr  = '0;
      emit     = 1'b0;
      emit_data.kind        = pcpc_pkg::KIND_GIVE;
      emit_data.class_out   = q_data.size_class;
      emit_data.pointer_out = q_data.chunk_pointer;
      emit_data.last        = 1'b1;

      case (state_ff)
         S_IDLE: begin
            if (q_valid && out_free) begin
               q_pop = 1'b1;
               case (q_data.code)
                  pcpc_pkg::CMD_PUSH: begin
                     if (q_data.bad_class) begin
                        emit = 1'b1;
                     end else begin
                        rate_in[q_data.cls_idx] = CW'(1);
                        if (count_ff[q_data.cls_idx] < CW'(pcpc_pkg::STACK_DEPTH)) begin
                           wr_en   = 1'b1;
                           wr_addr = {q_data.cls_idx,
                                      count_ff[q_data.cls_idx][pcpc_pkg::SLOT_W-1:0]};
                           count_in[q_data.cls_idx] = count_ff[q_data.cls_idx] + CW'(1);
                        end else begin
                           emit = 1'b1;
                        end
                     end
                  end
                  pcpc_pkg::CMD_POP: begin
                     emit_data.kind        = pcpc_pkg::KIND_MISS;
                     emit_data.pointer_out = '0;
                     if (q_data.bad_class) begin
                        emit = 1'b1;
                     end else begin
                        rate_in[q_data.cls_idx] = CW'(1);
                        if (count_ff[q_data.cls_idx] != '0) begin
                           count_in[q_data.cls_idx] = cnt_m1;
                           rd_en    = 1'b1;
                           rd_addr  = {q_data.cls_idx, cnt_m1[pcpc_pkg::SLOT_W-1:0]};
                           cls_in   = q_data.cls_idx;
                           state_in = S_POP_RD;
                        end else begin
                           emit = 1'b1;
                        end
                     end
                  end
                  pcpc_pkg::CMD_PURGE: begin
                     n_in     = '0;
                     cur_in   = '0;
                     state_in = S_SCAN;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_POP_RD: begin
            if (out_free) begin
               emit                  = 1'b1;
               emit_data.kind        = pcpc_pkg::KIND_HIT;
               emit_data.class_out   = pcpc_pkg::idx_to_field(cls_ff);
               emit_data.pointer_out = rd_data_ff;
               state_in              = S_IDLE;
            end
         end
         S_SCAN: begin
            if (s_found && (SW'(n_ff) + SW'(s_take) <= SW'(pcpc_pkg::MAX_RESULTS))) begin
               cls_in   = s_idx;
               take_in  = s_take;
               i_in     = '0;
               rd_en    = 1'b1;
               rd_addr  = {s_idx, s_top[pcpc_pkg::SLOT_W-1:0]};
               state_in = S_GIVE;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_GIVE: begin
            if (out_free) begin
               emit                  = 1'b1;
               emit_data.kind        = pcpc_pkg::KIND_GIVE;
               emit_data.class_out   = pcpc_pkg::idx_to_field(cls_ff);
               emit_data.pointer_out = rd_data_ff;
               emit_data.last        = last_slot && !more;
               if (last_slot) begin
                  count_in[cls_ff] = cnt_c - take_ff;
                  rate_in[cls_ff]  = rate_next;
                  n_in             = n_ff + pcpc_pkg::NRES_W'(take_ff);
                  cur_in           = pcpc_pkg::CLS_CNT_W'(cls_ff) + pcpc_pkg::CLS_CNT_W'(1);
                  state_in         = S_SCAN;
               end else begin
                  i_in    = i_ff + CW'(1);
                  rd_en   = 1'b1;
                  rd_addr = {cls_ff, slot_off[pcpc_pkg::SLOT_W-1:0]};
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_valid_in = emit || (rsp_valid_ff && rsp_stall);
      rsp_in       = emit ? emit_data : rsp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         cls_ff       <= '0;
         cur_ff       <= '0;
         take_ff      <= '0;
         i_ff         <= '0;
         n_ff         <= '0;
         for (int k = 0; k < pcpc_pkg::NUM_CLASSES; k++) begin
            count_ff[k] <= '0;
            rate_ff[k]  <= CW'(1);
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cls_ff       <= cls_in;
         cur_ff       <= cur_in;
         take_ff      <= take_in;
         i_ff         <= i_in;
         n_ff         <= n_in;
         count_ff     <= count_in;
         rate_ff      <= rate_in;
      end
      rsp_ff <= rsp_in;
   end

   // Pointer stacks, one write port and one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         stack_mem_ff[wr_addr] <= q_data.chunk_pointer;
      end
      if (rd_en) begin
         rd_data_ff <= stack_mem_ff[rd_addr];
      end
   end

`ifndef SYNTHESIS
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.kind == pcpc_pkg::KIND_MISS |-> rsp_ff.pointer_out == '0)
      else $error("miss carries a nonzero pointer");

   a_give_index: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_GIVE |-> (take_ff != '0 && i_ff < take_ff))
      else $error("purge slot index out of range");

   a_result_cap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN || state_ff == S_GIVE) |->
         SW'(n_ff) <= SW'(pcpc_pkg::MAX_RESULTS))
      else $error("purge result count over limit");

   a_hit_source: assert property (@(posedge clock) disable iff (reset)
      emit && emit_data.kind == pcpc_pkg::KIND_HIT |-> state_ff == S_POP_RD)
      else $error("hit issued outside pop read");
`endif

endmodule

`default_nettype wire

// ----- rtl/per_class_pointer_cache_with_decay.sv -----
// Channel  Ports                                   Direction  Transfer when
// -------  --------------------------------------  ---------  ----------------------
// request  req_valid, req_stall, req_data          in         req_valid && !req_stall
// response rsp_valid, rsp_stall, rsp_data          out        rsp_valid && !rsp_stall
//
// Flow: a request is queued in the cycle after transfer; a push is done in S_IDLE,
//   a pop in S_IDLE and S_POP_RD (one registered read of the pointer stack memory).
// Purge: accepted in S_IDLE; S_SCAN then picks each non-empty class in turn and S_GIVE
//   returns one pointer per cycle while the output register is free; a final S_SCAN
//   goes back to idle. The single stack memory read port sets this pace.
// Reset: synchronous, active high; counts clear to zero, decay rates to one. Stack
//   memory is not cleared, only entries below a class's count are ever read.
// Stalls: a two-entry command queue lets requests land while a result waits in the
//   output register; req_stall rises only when that queue is full.
`default_nettype none

module per_class_pointer_cache_with_decay (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire pcpc_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output pcpc_pkg::rsp_type      rsp_data
);

   // front end -> queue
   logic              q_wr;
   pcpc_pkg::cmd_type q_wr_data;
   logic              q_full;
   // queue -> back end
   logic              q_pop;
   logic              q_valid;
   pcpc_pkg::cmd_type q_rd_data;

   // Decode and range check; operation three is dropped here
   pcpc_front u_front (
      .req_valid (req_valid),
      .req_data  (req_data),
      .req_stall (req_stall),
      .q_full    (q_full),
      .q_wr      (q_wr),
      .q_data    (q_wr_data)
   );

   // Decouples request intake from stack execution
   pcpc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (q_wr),
      .wr_data   (q_wr_data),
      .full      (q_full),
      .rd_en     (q_pop),
      .rd_data   (q_rd_data),
      .not_empty (q_valid)
   );

   // Stack memory, counts, decay rates, purge walk and output register
   pcpc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_data    (q_rd_data),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// ----- bench/testbench.sv -----
`default_nettype none

module testbench;

   // Operation code 3 is undefined; the cache must drop it silently
   localparam logic [pcpc_pkg::OP_W-1:0] OP_IGNORED = 2'd3;

   // Flow-control phases
   localparam logic [1:0] PH_STEADY        = 2'd0;
   localparam logic [1:0] PH_SENDER_IDLE   = 2'd1;
   localparam logic [1:0] PH_RECEIVER_STALL = 2'd2;
   localparam logic [1:0] PH_BOTH_IDLE     = 2'd3;

   localparam int CLOCK_PERIOD = 12;
   localparam int LIMIT_CYCLES = 400000;
   localparam int DRAIN_CYCLES = 40;   // pushes and empty purges may still be in flight
   localparam int RANDOM_OPS   = 500;
   localparam int CHUNK_OPS    = 40;

   typedef struct packed {
      logic [1:0]        phase;
      pcpc_pkg::req_type data;
   } queued_op_type;

   logic              clock;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   pcpc_pkg::req_type req_data  = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   pcpc_pkg::rsp_type rsp_data;

   // Operations waiting to be driven, and results the cache still owes us
   queued_op_type     op_backlog [$];
   pcpc_pkg::rsp_type owed_results [$];

   // Shadow copy of the cache state
   logic [pcpc_pkg::PTR_W-1:0] shadow_stack [pcpc_pkg::NUM_CLASSES][pcpc_pkg::STACK_DEPTH];
   int                         shadow_fill  [pcpc_pkg::NUM_CLASSES];
   int                         shadow_rate  [pcpc_pkg::NUM_CLASSES];

   int            fail_count = 0;
   int            req_takes  = 0;  // request transfers seen by the monitor
   int            req_seen   = 0;  // request transfers already handled by the driver
   logic [1:0]    live_phase = PH_STEADY;
   queued_op_type next_op;

   per_class_pointer_cache_with_decay uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   function automatic int sender_idle_pct(input logic [1:0] phase);
      case (phase)
         PH_SENDER_IDLE: return 62;
         PH_BOTH_IDLE:   return 18;
         default:        return 0;
      endcase
   endfunction

   function automatic int receiver_stall_pct(input logic [1:0] phase);
      case (phase)
         PH_RECEIVER_STALL: return 62;
         PH_BOTH_IDLE:      return 18;
         default:           return 0;
      endcase
   endfunction

   // Work out what one accepted operation does to the cache and what it returns
   task automatic apply_cache_op(input pcpc_pkg::req_type r);
      pcpc_pkg::rsp_type res;
      pcpc_pkg::rsp_type held;
      int      cls;
      int      cnt;
      int      rt;
      int      take;
      int      given;
      logic    have_held;
      res       = '0;
      held      = '0;
      cls       = int'(r.size_class);
      given     = 0;
      have_held = 1'b0;
      case (r.operation)
         pcpc_pkg::OP_PUSH: begin
            if (cls < pcpc_pkg::NUM_CLASSES) shadow_rate[cls] = 1;
            if (cls < pcpc_pkg::NUM_CLASSES && shadow_fill[cls] < pcpc_pkg::STACK_DEPTH) begin
               shadow_stack[cls][shadow_fill[cls]] = r.chunk_pointer;
               shadow_fill[cls]++;
            end else begin
               // full stack (or bad class): pointer goes straight back to the bin
               res.kind        = pcpc_pkg::KIND_GIVE;
               res.class_out   = r.size_class;
               res.pointer_out = r.chunk_pointer;
               res.last        = 1'b1;
               owed_results.push_back(res);
            end
         end
         pcpc_pkg::OP_POP: begin
            res.class_out = r.size_class;
            res.last      = 1'b1;
            if (cls < pcpc_pkg::NUM_CLASSES) shadow_rate[cls] = 1;
            if (cls < pcpc_pkg::NUM_CLASSES && shadow_fill[cls] != 0) begin
               shadow_fill[cls]--;
               res.kind        = pcpc_pkg::KIND_HIT;
               res.pointer_out = shadow_stack[cls][shadow_fill[cls]];
            end else begin
               res.kind        = pcpc_pkg::KIND_MISS;
               res.pointer_out = '0;
            end
            owed_results.push_back(res);
         end
         pcpc_pkg::OP_PURGE: begin
            // One result is held back so the final one can carry last
            for (int c = 0; c < pcpc_pkg::NUM_CLASSES; c++) begin
               cnt = shadow_fill[c];
               rt  = shadow_rate[c];
               if (cnt == 0) continue;
               take = (rt < cnt) ? rt : cnt;
               if (given + take > pcpc_pkg::MAX_RESULTS) break;
               for (int i = 0; i < take; i++) begin
                  if (have_held) owed_results.push_back(held);
                  held.kind        = pcpc_pkg::KIND_GIVE;
                  held.class_out   = pcpc_pkg::CLASS_W'(c);
                  held.pointer_out = shadow_stack[c][cnt - 1 - i];
                  held.last        = 1'b0;
                  have_held        = 1'b1;
                  given++;
               end
               shadow_fill[c] = cnt - take;
               shadow_rate[c] = (2 * rt < pcpc_pkg::STACK_DEPTH) ? 2 * rt : pcpc_pkg::STACK_DEPTH;
            end
            if (have_held) begin
               held.last = 1'b1;
               owed_results.push_back(held);
            end
         end
         default: ;
      endcase
   endtask

   task automatic report_field(input string name, input logic [pcpc_pkg::PTR_W-1:0] want_v,
                               input logic [pcpc_pkg::PTR_W-1:0] got_v);
      if (got_v !== want_v) begin
         $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want_v, got_v);
         fail_count++;
      end
   endtask

   task automatic check_result(input pcpc_pkg::rsp_type got);
      pcpc_pkg::rsp_type want;
      if (owed_results.size() == 0) begin
         $display("%0t: unexpected result: kind %0d class %0d pointer %h last %0d",
                  $time, got.kind, got.class_out, got.pointer_out, got.last);
         fail_count++;
      end else begin
         want = owed_results.pop_front();
         report_field("kind", pcpc_pkg::PTR_W'(want.kind), pcpc_pkg::PTR_W'(got.kind));
         report_field("class_out", pcpc_pkg::PTR_W'(want.class_out),
                      pcpc_pkg::PTR_W'(got.class_out));
         report_field("pointer_out", want.pointer_out, got.pointer_out);
         report_field("last", pcpc_pkg::PTR_W'(want.last), pcpc_pkg::PTR_W'(got.last));
      end
   endtask

   task automatic queue_op(input logic [pcpc_pkg::OP_W-1:0] op,
                           input logic [pcpc_pkg::CLASS_W-1:0] cls,
                           input logic [pcpc_pkg::PTR_W-1:0] ptr, input logic [1:0] phase);
      queued_op_type item;
      item.phase              = phase;
      item.data.operation     = op;
      item.data.size_class    = cls;
      item.data.chunk_pointer = ptr;
      op_backlog.push_back(item);
   endtask

   // Monitor: both channels are sampled at the rising edge. A request transfer
   // feeds the shadow model, a response transfer is checked against it.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            apply_cache_op(req_data);
            req_takes++;
         end
         if (rsp_valid && !rsp_stall) check_result(rsp_data);
      end
   end

   // Driver: inputs change on the falling edge. A request is held until its
   // transfer; valid gets at most one assignment per edge.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         rsp_stall <= 1'b0;
      end else begin
         if (!req_valid || req_takes != req_seen) begin
            if (op_backlog.size() != 0 &&
                $urandom_range(99) >= sender_idle_pct(op_backlog[0].phase)) begin
               next_op    = op_backlog.pop_front();
               live_phase = next_op.phase;
               req_data  <= next_op.data;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
         req_seen   = req_takes;
         rsp_stall <= ($urandom_range(99) < receiver_stall_pct(live_phase));
      end
   end

   initial begin
      int                           effective;
      int                           chunk;
      int                           focus;
      int                           push_pct;
      int                           purge_pct;
      int                           roll;
      logic [1:0]                   phase;
      logic [pcpc_pkg::CLASS_W-1:0] base;
      logic [pcpc_pkg::CLASS_W-1:0] cls;
      logic [pcpc_pkg::OP_W-1:0]    op;
      logic [pcpc_pkg::PTR_W-1:0]   ptr;

      for (int c = 0; c < pcpc_pkg::NUM_CLASSES; c++) begin
         shadow_fill[c] = 0;
         shadow_rate[c] = 1;
      end

      // Directed: misses on empty stacks, empty purge, overflow of one class,
      // hits, purges with the rate doubling to drain, and the undefined code
      queue_op(pcpc_pkg::OP_POP,   3'd0, '0, PH_STEADY);
      queue_op(pcpc_pkg::OP_POP,   3'd7, '0, PH_STEADY);
      queue_op(pcpc_pkg::OP_PURGE, 3'd0, '0, PH_STEADY);
      queue_op(pcpc_pkg::OP_PUSH,  3'd7, 48'h0000_0000_0000, PH_STEADY);
      queue_op(pcpc_pkg::OP_PUSH,  3'd7, 48'hFFFF_FFFF_FFFF, PH_STEADY);
      queue_op(pcpc_pkg::OP_PUSH,  3'd7, 48'hAAAA_AAAA_AAAA, PH_STEADY);
      queue_op(pcpc_pkg::OP_PUSH,  3'd7, 48'h5555_5555_5555, PH_STEADY);
      queue_op(pcpc_pkg::OP_PUSH,  3'd7, 48'h0000_0000_0001, PH_STEADY);
      queue_op(pcpc_pkg::OP_PUSH,  3'd7, 48'h8000_0000_0000, PH_STEADY);
      queue_op(pcpc_pkg::OP_PUSH,  3'd7, 48'h7FFF_FFFF_FFFF, PH_STEADY);
      queue_op(pcpc_pkg::OP_PUSH,  3'd7, 48'h0123_4567_89AB, PH_STEADY);
      queue_op(pcpc_pkg::OP_PUSH,  3'd7, 48'hFEDC_BA98_7654, PH_STEADY);  // full: given back
      queue_op(pcpc_pkg::OP_PUSH,  3'd0, 48'hFFFF_FFFF_FFFF, PH_STEADY);
      queue_op(pcpc_pkg::OP_POP,   3'd0, 48'hFFFF_FFFF_FFFF, PH_STEADY);
      queue_op(pcpc_pkg::OP_POP,   3'd7, '0, PH_STEADY);
      queue_op(pcpc_pkg::OP_PUSH,  3'd3, 48'h1357_9BDF_2468, PH_STEADY);
      queue_op(pcpc_pkg::OP_PUSH,  3'd5, 48'hC0DE_0000_FACE, PH_STEADY);
      queue_op(pcpc_pkg::OP_PURGE, 3'd7, 48'hFFFF_FFFF_FFFF, PH_STEADY);
      queue_op(pcpc_pkg::OP_PURGE, 3'd0, '0, PH_STEADY);
      queue_op(pcpc_pkg::OP_PURGE, 3'd5, '0, PH_STEADY);
      queue_op(pcpc_pkg::OP_PURGE, 3'd0, '0, PH_STEADY);  // everything drained: no result
      queue_op(OP_IGNORED, 3'd5, 48'hFFFF_FFFF_FFFF, PH_STEADY);
      queue_op(pcpc_pkg::OP_POP,   3'd3, '0, PH_STEADY);

      // Random: chunks rotate through the flow-control phases; each chunk has
      // its own operation mix and either spreads over all classes or hammers
      // one or two, so stacks fill, overflow and decay.
      effective = 0;
      chunk     = 0;
      while (effective < RANDOM_OPS) begin
         phase     = 2'(chunk % 4);
         focus     = $urandom_range(2);
         base      = pcpc_pkg::CLASS_W'($urandom_range(pcpc_pkg::NUM_CLASSES - 1));
         push_pct  = 35 + $urandom_range(40);
         purge_pct = 4 + $urandom_range(12);
         for (int k = 0; k < CHUNK_OPS; k++) begin
            roll = $urandom_range(99);
            if (roll < 3) op = OP_IGNORED;
            else if (roll < 3 + purge_pct) op = pcpc_pkg::OP_PURGE;
            else if (roll < 3 + purge_pct + push_pct) op = pcpc_pkg::OP_PUSH;
            else op = pcpc_pkg::OP_POP;
            case (focus)
               0:       cls = pcpc_pkg::CLASS_W'($urandom_range(pcpc_pkg::NUM_CLASSES - 1));
               1:       cls = base;
               default: cls = base ^ pcpc_pkg::CLASS_W'($urandom_range(1));
            endcase
            ptr = pcpc_pkg::PTR_W'({$urandom, $urandom});
            case ($urandom_range(9))
               0:       ptr = '0;
               1:       ptr = '1;
               default: ;
            endcase
            queue_op(op, cls, ptr, phase);
            if (op != OP_IGNORED) effective++;
         end
         chunk++;
      end

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Every request transferred, every owed result back, then let the tail settle
      while (op_backlog.size() != 0 || req_valid) @(posedge clock);
      while (owed_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0) begin
         $display("** per_class_pointer_cache_with_decay: PASSED **");
      end else begin
         $display("** per_class_pointer_cache_with_decay: FAILED **");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #(CLOCK_PERIOD * LIMIT_CYCLES);
      $display("** per_class_pointer_cache_with_decay: FAILED **");
      $finish;
   end

endmodule

`default_nettype wire
